// ----- rtl/hdr_exposure_merge_defines.svh -----
// assertion macros shared by the hdr exposure merge rtl
`ifndef HDR_EXPOSURE_MERGE_DEFINES_SVH
`define HDR_EXPOSURE_MERGE_DEFINES_SVH

// check that holds in the same cycle as its condition
`define HEM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check that holds in the cycle after its condition
`define HEM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/hem_pkg.sv -----
// types and constants shared by the hdr exposure merge modules
package hem_pkg;

  localparam int CODE_BITS    = 16;
  localparam int VALUE_BITS   = 16;
  localparam int COEF_BITS    = 24;
  localparam int RAD_BITS     = 32;
  localparam int SUM_BITS     = 64;
  localparam int FRAC_BITS    = 16;
  localparam int WC_BITS      = VALUE_BITS + COEF_BITS;
  localparam int SPLIT_BITS   = WC_BITS / 2;
  localparam int PN_BITS      = VALUE_BITS + SPLIT_BITS;
  localparam int PD_BITS      = COEF_BITS + SPLIT_BITS;
  localparam int NUM_INC_BITS = VALUE_BITS + WC_BITS;
  localparam int DVD_BITS     = SUM_BITS + FRAC_BITS;
  localparam int DIV_STEPS    = DVD_BITS;
  localparam int DIV_CLIP_STEPS = DVD_BITS - RAD_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_CH       = 3;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] SEL_RED    = 2'd0;
  localparam logic [1:0] SEL_GREEN  = 2'd1;
  localparam logic [1:0] SEL_BLUE   = 2'd2;
  localparam logic [1:0] SEL_WEIGHT = 2'd3;

  localparam logic [1:0] LANE_SEL [NUM_CH] = '{SEL_RED, SEL_GREEN, SEL_BLUE};

  typedef struct packed {
    logic                  op;
    logic [1:0]            table_select;
    logic [CODE_BITS-1:0]  table_index;
    logic [VALUE_BITS-1:0] table_value;
    logic [CODE_BITS-1:0]  sample_red;
    logic [CODE_BITS-1:0]  sample_green;
    logic [CODE_BITS-1:0]  sample_blue;
    logic [COEF_BITS-1:0]  exposure_coef;
    logic                  last_frame;
  } in_item_t;

  typedef struct packed {
    logic [RAD_BITS-1:0] radiance_red;
    logic [RAD_BITS-1:0] radiance_green;
    logic [RAD_BITS-1:0] radiance_blue;
    logic                saturated;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_SAMPLE,
    KIND_LAST
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    in_item_t   data;
  } q_item_t;

  typedef struct packed {
    logic resp_we;
    logic weight_we;
    logic rd_en;
    logic mul1;
    logic mul2;
    logic comb;
    logic acc;
    logic div_load;
    logic div_step;
    logic div_hi;
  } lane_ctrl_t;

  typedef struct packed {
    logic [RAD_BITS-1:0] radiance;
    logic                clip;
  } lane_res_t;

endpackage

// ----- rtl/hem_ram.sv -----
// generic simple dual port ram with registered read
module hem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/hem_front.sv -----
// input queue that takes beats and tags each one as table write, sample or last sample
`include "hdr_exposure_merge_defines.svh"

module hem_front import hem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     head_valid,
  output q_item_t  head,
  input  logic     pop
);

  q_item_t              fifo_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 push;
  q_item_t              entry;

  assign in_ready   = (cnt_r != QCNT_BITS'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != '0);
  assign head       = fifo_r[rd_ptr_r];

  always_comb begin
    entry.data = in_data;
    if (in_data.op == OP_WRITE) begin
      entry.kind = KIND_WRITE;
    end else if (in_data.last_frame) begin
      entry.kind = KIND_LAST;
    end else begin
      entry.kind = KIND_SAMPLE;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= entry;
    end
  end

  `HEM_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= QCNT_BITS'(QUEUE_DEPTH), "queue count overrun")
  `HEM_ASSERT_SAME(a_pop_nonempty, pop, head_valid, "pop from empty queue")
  `HEM_ASSERT_NEXT(a_cnt_hold, !push && !pop, cnt_r == $past(cnt_r), "queue count moved idle")

endmodule

// ----- rtl/hem_lane.sv -----
// one color channel: table rams, weighted multiply-accumulate and serial q16.16 divider
module hem_lane import hem_pkg::*; #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lane_ctrl_t            ctrl,
  input  logic [LEVEL_BITS-1:0] waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic [LEVEL_BITS-1:0] raddr,
  input  logic [COEF_BITS-1:0]  coef,
  output lane_res_t             res
);

  localparam int LEVELS = 2 ** LEVEL_BITS;

  logic [VALUE_BITS-1:0]   resp_rd;
  logic [VALUE_BITS-1:0]   weight_rd;
  logic [WC_BITS-1:0]      wc_r;
  logic [PN_BITS-1:0]      pn_lo_r, pn_hi_r;
  logic [PD_BITS-1:0]      pd_lo_r, pd_hi_r;
  logic [NUM_INC_BITS-1:0] num_inc_r;
  logic [SUM_BITS-1:0]     den_inc_r;
  logic [SUM_BITS-1:0]     num_sum_r, num_sum_nxt;
  logic [SUM_BITS-1:0]     den_sum_r, den_sum_nxt;
  logic [SUM_BITS:0]       num_add, den_add;
  logic [DVD_BITS-1:0]     dvd_r;
  logic [SUM_BITS-1:0]     dvs_r;
  logic [SUM_BITS-1:0]     rem_r;
  logic [RAD_BITS-1:0]     quo_r;
  logic                    clip_r;
  logic                    dzero_r;
  logic [SUM_BITS:0]       rem_sh, diff;
  logic                    qbit;

  hem_ram #(.WIDTH(VALUE_BITS), .DEPTH(LEVELS)) u_resp_ram (
    .clk   (clk),
    .we    (ctrl.resp_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.rd_en),
    .raddr (raddr),
    .rdata (resp_rd)
  );

  hem_ram #(.WIDTH(VALUE_BITS), .DEPTH(LEVELS)) u_weight_ram (
    .clk   (clk),
    .we    (ctrl.weight_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.rd_en),
    .raddr (raddr),
    .rdata (weight_rd)
  );

  // saturating accumulate
  always_comb begin
    num_add     = {1'b0, num_sum_r} + (SUM_BITS + 1)'(num_inc_r);
    den_add     = {1'b0, den_sum_r} + {1'b0, den_inc_r};
    num_sum_nxt = num_add[SUM_BITS] ? '1 : num_add[SUM_BITS-1:0];
    den_sum_nxt = den_add[SUM_BITS] ? '1 : den_add[SUM_BITS-1:0];
  end

  // restoring divide step, remainder stays below the divisor when it is nonzero
  always_comb begin
    rem_sh = {rem_r, dvd_r[DVD_BITS-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    qbit   = !diff[SUM_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sum_r <= '0;
      den_sum_r <= '0;
    end else if (ctrl.div_load) begin
      num_sum_r <= '0;
      den_sum_r <= '0;
    end else if (ctrl.acc) begin
      num_sum_r <= num_sum_nxt;
      den_sum_r <= den_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul1) begin
      wc_r <= WC_BITS'(weight_rd) * WC_BITS'(coef);
    end
    if (ctrl.mul2) begin
      pn_lo_r <= PN_BITS'(resp_rd) * PN_BITS'(wc_r[SPLIT_BITS-1:0]);
      pn_hi_r <= PN_BITS'(resp_rd) * PN_BITS'(wc_r[WC_BITS-1:SPLIT_BITS]);
      pd_lo_r <= PD_BITS'(coef) * PD_BITS'(wc_r[SPLIT_BITS-1:0]);
      pd_hi_r <= PD_BITS'(coef) * PD_BITS'(wc_r[WC_BITS-1:SPLIT_BITS]);
    end
    if (ctrl.comb) begin
      num_inc_r <= NUM_INC_BITS'(pn_lo_r) + {pn_hi_r, {SPLIT_BITS{1'b0}}};
      den_inc_r <= SUM_BITS'(pd_lo_r) + {pd_hi_r, {SPLIT_BITS{1'b0}}};
    end
    if (ctrl.div_load) begin
      dvd_r   <= {num_sum_r, {FRAC_BITS{1'b0}}};
      dvs_r   <= den_sum_r;
      rem_r   <= '0;
      quo_r   <= '0;
      clip_r  <= 1'b0;
      dzero_r <= (den_sum_r == '0);
    end else if (ctrl.div_step) begin
      dvd_r  <= {dvd_r[DVD_BITS-2:0], 1'b0};
      rem_r  <= qbit ? diff[SUM_BITS-1:0] : rem_sh[SUM_BITS-1:0];
      quo_r  <= {quo_r[RAD_BITS-2:0], qbit};
      // any quotient bit above the low 32 means overflow
      clip_r <= clip_r | (qbit & ctrl.div_hi);
    end
  end

  always_comb begin
    if (dzero_r) begin
      res.radiance = '0;
    end else if (clip_r) begin
      res.radiance = '1;
    end else begin
      res.radiance = quo_r;
    end
    res.clip = clip_r && !dzero_r;
  end

endmodule

// ----- rtl/hem_back.sv -----
// sequencer that runs queued items through the three channel lanes and holds the result
`include "hdr_exposure_merge_defines.svh"

module hem_back import hem_pkg::*; #(
  parameter int LEVEL_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  q_item_t   head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL1  = 8'b0000_0010,
    S_MUL2  = 8'b0000_0100,
    S_COMB  = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_DLOAD = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [DIV_CNT_BITS-1:0] div_cnt_r, div_cnt_nxt;
  logic [COEF_BITS-1:0]    coef_r;
  logic                    last_r;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r;
  logic                    load_out;
  logic                    wr_go;
  lane_ctrl_t              ctrl_base;
  lane_ctrl_t              lane_ctrl [NUM_CH];
  lane_res_t               lane_res [NUM_CH];
  logic [LEVEL_BITS-1:0]   codes [NUM_CH];

  assign wr_go = pop && (head.kind == KIND_WRITE);

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    pop         = 1'b0;
    load_out    = 1'b0;
    ctrl_base   = '0;
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.kind)
            KIND_SAMPLE, KIND_LAST: begin
              ctrl_base.rd_en = 1'b1;
              state_nxt       = S_MUL1;
            end
            default: begin
              ctrl_base.weight_we = (head.data.table_select == SEL_WEIGHT);
            end
          endcase
        end
      end
      S_MUL1: begin
        ctrl_base.mul1 = 1'b1;
        state_nxt      = S_MUL2;
      end
      S_MUL2: begin
        ctrl_base.mul2 = 1'b1;
        state_nxt      = S_COMB;
      end
      S_COMB: begin
        ctrl_base.comb = 1'b1;
        state_nxt      = S_ACC;
      end
      S_ACC: begin
        ctrl_base.acc = 1'b1;
        state_nxt     = last_r ? S_DLOAD : S_IDLE;
      end
      S_DLOAD: begin
        ctrl_base.div_load = 1'b1;
        div_cnt_nxt        = '0;
        state_nxt          = S_DIV;
      end
      S_DIV: begin
        ctrl_base.div_step = 1'b1;
        ctrl_base.div_hi   = (div_cnt_r < DIV_CNT_BITS'(DIV_CLIP_STEPS));
        if (div_cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          state_nxt = S_OUT;
        end else begin
          div_cnt_nxt = div_cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    codes[0] = head.data.sample_red[LEVEL_BITS-1:0];
    codes[1] = head.data.sample_green[LEVEL_BITS-1:0];
    codes[2] = head.data.sample_blue[LEVEL_BITS-1:0];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      lane_ctrl[ch]         = ctrl_base;
      lane_ctrl[ch].resp_we = wr_go && (head.data.table_select == LANE_SEL[ch]);
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    hem_lane #(.LEVEL_BITS(LEVEL_BITS)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl[ch]),
      .waddr (head.data.table_index[LEVEL_BITS-1:0]),
      .wdata (head.data.table_value),
      .raddr (codes[ch]),
      .coef  (coef_r),
      .res   (lane_res[ch])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      coef_r <= head.data.exposure_coef;
      last_r <= (head.kind == KIND_LAST);
    end
    if (load_out) begin
      out_data_r.radiance_red   <= lane_res[0].radiance;
      out_data_r.radiance_green <= lane_res[1].radiance;
      out_data_r.radiance_blue  <= lane_res[2].radiance;
      out_data_r.saturated      <= lane_res[0].clip | lane_res[1].clip | lane_res[2].clip;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HEM_ASSERT_NEXT(a_div_exit, (state_r == S_DIV) && (div_cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)), state_r == S_OUT, "divider did not finish on its last step")
  `HEM_ASSERT_NEXT(a_out_source, !out_valid_r && (state_r != S_OUT), !out_valid_r, "result shown without a finished pixel")
  `HEM_ASSERT_NEXT(a_out_hold, (state_r == S_OUT) && out_valid_r && !out_ready, (state_r == S_OUT) && out_valid_r, "waiting result overwritten")

endmodule

// ----- rtl/hdr_exposure_merge.sv -----
// top level of the weighted hdr exposure merge: input queue feeding the channel sequencer
// an item passes the queue register; a table write completes in the idle state, a plain sample
// steps through mul1, mul2, comb and acc; one marked last goes on through dload, div and out
// throughput: one table write per cycle while idle; no item is taken before the last is done;
// a pixel end waits on the 80 step serial divider, one quotient bit per cycle in each channel
// reset clears the queue, sequencer, accumulators and output valid; table rams keep contents
module hdr_exposure_merge import hem_pkg::*; #(
  parameter int LEVEL_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic    head_valid;
  q_item_t head;
  logic    pop;

  hem_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  hem_back #(.LEVEL_BITS(LEVEL_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
